// ----- design/ile_pkg.sv -----
// ile_pkg: operation and status codes and the cell control struct
// for the indexed list engine; no dependencies
package ile_pkg;

  // list operations carried in the operation field
  typedef enum logic [3:0] {
    OP_INS_HEAD = 4'd0,
    OP_INS_TAIL = 4'd1,
    OP_INS_AT   = 4'd2,
    OP_RM_HEAD  = 4'd3,
    OP_RM_TAIL  = 4'd4,
    OP_RM_AT    = 4'd5,
    OP_READ     = 4'd6,
    OP_REPLACE  = 4'd7,
    OP_EXISTS   = 4'd8,
    OP_EQUAL_AT = 4'd9,
    OP_SWAP     = 4'd10,
    OP_CLEAR    = 4'd11
  } ile_op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } ile_status_t;

  // broadcast control to every cell of the chain, at most one bit set
  typedef struct packed {
    logic ins;  // open a gap at the target and load the new word
    logic rm;   // close the gap at the target
    logic put;  // overwrite the target with the new word
    logic swp;  // exchange the words at both targets
  } ile_cell_ctl_t;

endpackage

// ----- design/ile_if.sv -----
// ile_if: valid/ready channel interfaces for list operations and results
// no dependencies
interface ile_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [31:0] value;
  logic [5:0]  position;
  logic [5:0]  other_position;

  modport source (output valid, output operation, output value, output position,
                  output other_position, input ready);
  modport sink   (input valid, input operation, input value, input position,
                  input other_position, output ready);
endinterface

interface ile_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic        matched;
  logic [1:0]  status;
  logic [6:0]  item_count;
  logic        is_empty;

  modport source (output valid, output read_value, output matched, output status,
                  output item_count, output is_empty, input ready);
  modport sink   (input valid, input read_value, input matched, input status,
                  input item_count, input is_empty, output ready);
endinterface

// ----- design/indexed_list_engine.sv -----
// indexed_list_engine: ordered list of signed words kept in a chain of cells
// depends on ile_pkg, ile_if (ile_in_if, ile_out_if) and ile_cell
//
//  channel  dir  modport           transfer moves
//  in_ch    in   ile_in_if.sink    operation, value, position, other_position
//  out_ch   out  ile_out_if.source read_value, matched, status, item_count, is_empty
//
// one operation per cycle while the output side keeps up: every cell updates in the
// transfer cycle and the result appears in the output register on the next cycle.
// throughput is set by the output register: a new item is taken whenever the
// register is empty or its result is taken in the same cycle.
// rst_n (synchronous) empties the list and the output register; cell
// contents are not reset and are read only after being written.
module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ile_in_if.sink    in_ch,
  ile_out_if.source out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = (CNT_W > 6) ? CNT_W : 6;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic [31:0]           read_value_r;
  logic                  matched_r;
  ile_status_t           status_r;
  logic [6:0]            item_count_r;
  logic                  is_empty_r;

  logic                  in_fire;
  ile_op_t               op;
  logic [DATA_WIDTH-1:0] val_word;
  logic [POS_W-1:0]      pos_ext;
  logic [POS_W-1:0]      pos2_ext;
  logic [POS_W-1:0]      count_ext;
  logic [IDX_W-1:0]      pos_ix;
  logic [IDX_W-1:0]      pos2_ix;
  logic                  in_range;
  logic                  in_range2;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] word_at_pos;
  logic [DATA_WIDTH-1:0] word_at_pos2;

  ile_cell_ctl_t         ctl;
  ile_cell_ctl_t         cell_ctl;
  logic [IDX_W-1:0]      tgt;
  logic [31:0]           rd_val;
  logic                  match;
  ile_status_t           status;

  logic [DATA_WIDTH-1:0] word_w [CAPACITY];
  logic [CAPACITY-1:0]   hit_w;

  // handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // operand preparation
  assign op        = ile_op_t'(in_ch.operation);
  assign val_word  = DATA_WIDTH'($signed(in_ch.value));
  assign pos_ext   = POS_W'(in_ch.position);
  assign pos2_ext  = POS_W'(in_ch.other_position);
  assign count_ext = POS_W'(count_r);
  assign pos_ix    = pos_ext[IDX_W-1:0];
  assign pos2_ix   = pos2_ext[IDX_W-1:0];
  assign in_range  = pos_ext < count_ext;
  assign in_range2 = pos2_ext < count_ext;
  assign full      = count_r == CNT_W'(CAPACITY);
  assign empty     = count_r == '0;

  // words at the two addressed positions
  assign word_at_pos  = word_w[pos_ix];
  assign word_at_pos2 = word_w[pos2_ix];

  // operation decoder
  always_comb begin
    ctl       = '0;
    tgt       = pos_ix;
    rd_val    = '0;
    match     = 1'b0;
    status    = ST_OK;
    count_nxt = count_r;
    unique case (op)
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          tgt       = (op == OP_INS_HEAD) ? '0 : count_r[IDX_W-1:0];
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_INS_AT: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_RM_HEAD: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.rm    = 1'b1;
          tgt       = '0;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_RM_TAIL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_RM_AT: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          ctl.rm    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          rd_val = 32'($signed(word_at_pos));
        end
      end
      OP_REPLACE: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          ctl.put = 1'b1;
        end
      end
      OP_EXISTS: begin
        match = |hit_w;
      end
      OP_EQUAL_AT: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          match = word_at_pos == val_word;
        end
      end
      OP_SWAP: begin
        if (pos_ext != pos2_ext) begin
          if (!in_range || !in_range2) begin
            status = ST_RANGE;
          end else begin
            ctl.swp = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // cells act only on a transfer
  assign cell_ctl = in_fire ? ctl : '0;

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = val_word;
    end else begin : g_mid_l
      assign left_w = word_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = word_w[i];
    end else begin : g_mid_r
      assign right_w = word_w[i+1];
    end

    ile_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .tgt        (tgt),
      .tgt2       (pos2_ix),
      .count      (count_r),
      .new_word   (val_word),
      .swap_a     (word_at_pos),
      .swap_b     (word_at_pos2),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (word_w[i]),
      .hit        (hit_w[i])
    );
  end

  // element count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_value_r <= rd_val;
      matched_r    <= match;
      status_r     <= status;
      item_count_r <= 7'(count_nxt);
      is_empty_r   <= count_nxt == '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = read_value_r;
  assign out_ch.matched    = matched_r;
  assign out_ch.status     = status_r;
  assign out_ch.item_count = item_count_r;
  assign out_ch.is_empty   = is_empty_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_count_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r && (item_count_r == 7'(count_r)))
    else $error("reported count differs from stored count");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (is_empty_r == (count_r == '0)))
    else $error("empty flag differs from stored count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_FULL)) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status while store not full");

endmodule

// ----- design/ile_cell.sv -----
// ile_cell: one storage cell of the list chain, holds one word and
// shifts to or from its neighbors; depends on ile_pkg
module ile_cell
  import ile_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  ile_cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]      tgt,
  input  logic [IDX_W-1:0]      tgt2,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] new_word,
  input  logic [DATA_WIDTH-1:0] swap_a,
  input  logic [DATA_WIDTH-1:0] swap_b,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  output logic [DATA_WIDTH-1:0] word,
  output logic                  hit
);

  localparam logic [IDX_W-1:0] MY_IX  = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  // next word from the broadcast command
  always_comb begin
    word_nxt = word_r;
    if (ctl.ins) begin
      if (MY_IX == tgt) begin
        word_nxt = new_word;
      end else if (MY_IX > tgt) begin
        word_nxt = left_word;
      end
    end else if (ctl.rm) begin
      if (MY_IX >= tgt) begin
        word_nxt = right_word;
      end
    end else if (ctl.put) begin
      if (MY_IX == tgt) begin
        word_nxt = new_word;
      end
    end else if (ctl.swp) begin
      if (MY_IX == tgt) begin
        word_nxt = swap_b;
      end else if (MY_IX == tgt2) begin
        word_nxt = swap_a;
      end
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // membership compare, only for occupied cells
  assign hit  = (MY_CNT < count) && (word_r == new_word);
  assign word = word_r;

endmodule

// ----- tb/list_result_checker.sv -----
// list_result_checker: watches both channels of the indexed list engine,
// predicts each result from its own copy of the list and compares field by field
// depends on ile_pkg and ile_if (ile_in_if, ile_out_if)
module list_result_checker
  import ile_pkg::*;
#(
  parameter int LIST_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  ile_in_if    in_mon,
  ile_out_if   out_mon,
  output int   fail_count,
  output int   outstanding,
  output int   occupancy,
  output int   checked_count,
  output int   full_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] read_value;
    logic        matched;
    ile_status_t status;
    logic [6:0]  item_count;
    logic        is_empty;
  } list_result_t;

  list_result_t pending_results[$];
  logic [31:0]  shadow_words[LIST_DEPTH];
  int           shadow_count;

  // apply one operation to the shadow list and return the result it gives
  function automatic list_result_t apply_list_op(input logic [3:0] op,
                                                 input logic [31:0] value,
                                                 input logic [5:0] pos,
                                                 input logic [5:0] pos2);
    list_result_t res;
    int           target;
    int           i;
    logic [31:0]  tmp;
    logic         in_range;
    res = '0;
    res.status = ST_OK;
    in_range = int'(pos) < shadow_count;
    case (op)
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
        target = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_TAIL) ? shadow_count : int'(pos);
        // range check takes priority over the full check
        if (op == OP_INS_AT && !in_range) begin
          res.status = ST_RANGE;
        end else if (shadow_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > target; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[target] = value;
          shadow_count++;
        end
      end
      OP_RM_HEAD, OP_RM_TAIL: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op == OP_RM_HEAD)
            for (i = 0; i < shadow_count - 1; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      OP_RM_AT: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          for (i = int'(pos); i < shadow_count - 1; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (!in_range) res.status = ST_RANGE;
        else res.read_value = shadow_words[pos];
      end
      OP_REPLACE: begin
        if (!in_range) res.status = ST_RANGE;
        else shadow_words[pos] = value;
      end
      OP_EXISTS: begin
        for (i = 0; i < shadow_count; i++)
          if (shadow_words[i] == value) res.matched = 1'b1;
      end
      OP_EQUAL_AT: begin
        if (!in_range) res.status = ST_RANGE;
        else res.matched = (shadow_words[pos] == value);
      end
      OP_SWAP: begin
        // a swap of a position with itself is a no-op, even out of range
        if (pos != pos2) begin
          if (!in_range || int'(pos2) >= shadow_count) begin
            res.status = ST_RANGE;
          end else begin
            tmp = shadow_words[pos];
            shadow_words[pos] = shadow_words[pos2];
            shadow_words[pos2] = tmp;
          end
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    res.item_count = shadow_count[6:0];
    res.is_empty = (shadow_count == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // result transfers are checked before the input transfer of the same edge
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      shadow_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", out_mon.read_value, '0);
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (out_mon.read_value !== want.read_value)
            report_mismatch("read_value", out_mon.read_value, want.read_value);
          if (out_mon.matched !== want.matched)
            report_mismatch("matched", 32'(out_mon.matched), 32'(want.matched));
          if (out_mon.status !== want.status)
            report_mismatch("status", 32'(out_mon.status), 32'(want.status));
          if (out_mon.item_count !== want.item_count)
            report_mismatch("item_count", 32'(out_mon.item_count), 32'(want.item_count));
          if (out_mon.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(out_mon.is_empty), 32'(want.is_empty));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = apply_list_op(in_mon.operation, in_mon.value, in_mon.position,
                             in_mon.other_position);
        if (want.status == ST_FULL) full_hits++;
        pending_results.push_back(want);
      end
    end
    outstanding = pending_results.size();
    occupancy = shadow_count;
  end

endmodule

// ----- tb/indexed_list_engine_tb.sv -----
// indexed_list_engine_tb: clock, reset, directed and random list operations
// with random idling on both channels; verdict from list_result_checker
// depends on ile_pkg, ile_if, indexed_list_engine and list_result_checker
module indexed_list_engine_tb
  import ile_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] OP_UNUSED_LO = 4'd12;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam int LIST_DEPTH    = 64;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 175;
  localparam int SETTLE_CYCLES = 20;

  typedef enum {PROF_FILL, PROF_DRAIN, PROF_MIXED, PROF_NOISE} op_profile_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ile_in_if  in_ch();
  ile_out_if out_ch();

  int fail_count;
  int outstanding;
  int occupancy;
  int checked_count;
  int full_hits;
  int items_sent;
  bit tx_no_gaps;
  bit rx_no_stalls;
  logic [31:0] recent_vals[8];

  op_profile_t phase_plan[RANDOM_PHASES] = '{PROF_FILL, PROF_MIXED, PROF_FILL, PROF_DRAIN,
                                             PROF_NOISE, PROF_MIXED, PROF_FILL, PROF_DRAIN,
                                             PROF_MIXED, PROF_NOISE};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indexed_list_engine #(
    .CAPACITY  (LIST_DEPTH),
    .DATA_WIDTH(32)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  list_result_checker #(
    .LIST_DEPTH(LIST_DEPTH)
  ) result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .occupancy    (occupancy),
    .checked_count(checked_count),
    .full_hits    (full_hits)
  );

  // one operation transfer, after a random gap drawn per item
  task automatic send_op(input logic [3:0] op, input logic [31:0] value,
                         input logic [5:0] pos, input logic [5:0] pos2);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.operation = op;
    in_ch.value = value;
    in_ch.position = pos;
    in_ch.other_position = pos2;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (op inside {OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT, OP_REPLACE})
      recent_vals[$urandom_range(0, 7)] = value;
  endtask

  // values reuse stored words often so that membership tests can hit
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return recent_vals[$urandom_range(0, 7)];
    if (r < 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_op(input op_profile_t prof);
    int r;
    int ins_w;
    int rm_w;
    int clr_w;
    int junk_w;
    case (prof)
      PROF_FILL:  begin ins_w = 65; rm_w = 10; clr_w = 0; junk_w = 1; end
      PROF_DRAIN: begin ins_w = 15; rm_w = 50; clr_w = 2; junk_w = 1; end
      PROF_MIXED: begin ins_w = 35; rm_w = 20; clr_w = 1; junk_w = 2; end
      default:    begin ins_w = 30; rm_w = 25; clr_w = 3; junk_w = 8; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_w) begin
      case ($urandom_range(0, 2))
        0: return OP_INS_HEAD;
        1: return OP_INS_TAIL;
        default: return OP_INS_AT;
      endcase
    end
    if (r < ins_w + rm_w) begin
      case ($urandom_range(0, 2))
        0: return OP_RM_HEAD;
        1: return OP_RM_TAIL;
        default: return OP_RM_AT;
      endcase
    end
    if (r >= 100 - junk_w) return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (r >= 100 - junk_w - clr_w) return OP_CLEAR;
    case ($urandom_range(0, 4))
      0: return OP_READ;
      1: return OP_REPLACE;
      2: return OP_EXISTS;
      3: return OP_EQUAL_AT;
      default: return OP_SWAP;
    endcase
  endfunction

  // mostly valid positions, except in noise phases
  function automatic logic [5:0] pick_pos(input op_profile_t prof);
    if (prof != PROF_NOISE && occupancy > 0 && $urandom_range(0, 9) < 8)
      return 6'($urandom_range(0, occupancy - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // result side: random stall drawn per result
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = rx_no_stalls ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // stimulus and verdict
  initial begin
    op_profile_t prof;
    logic [3:0]  op;
    logic [5:0]  pos;
    logic [5:0]  pos2;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_INS_HEAD;
    in_ch.value = '0;
    in_ch.position = '0;
    in_ch.other_position = '0;
    for (int k = 0; k < 8; k++) recent_vals[k] = $urandom;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty-list errors, extremes, every operation
    send_op(OP_RM_HEAD, 32'h0, 6'd0, 6'd0);
    send_op(OP_RM_TAIL, 32'h0, 6'd0, 6'd0);
    send_op(OP_READ, 32'h0, 6'd0, 6'd0);
    send_op(OP_INS_AT, 32'h5, 6'd0, 6'd0);
    send_op(OP_SWAP, 32'h0, 6'd63, 6'd63);
    send_op(OP_EXISTS, 32'h0, 6'd0, 6'd0);
    send_op(OP_EQUAL_AT, 32'h0, 6'd0, 6'd0);
    send_op(OP_INS_HEAD, 32'h7fff_ffff, 6'd0, 6'd0);
    send_op(OP_INS_TAIL, 32'h8000_0000, 6'd0, 6'd0);
    send_op(OP_INS_AT, 32'hffff_ffff, 6'd1, 6'd0);
    send_op(OP_READ, 32'h0, 6'd0, 6'd0);
    send_op(OP_READ, 32'h0, 6'd1, 6'd0);
    send_op(OP_READ, 32'h0, 6'd2, 6'd0);
    send_op(OP_READ, 32'h0, 6'd3, 6'd0);
    send_op(OP_REPLACE, 32'h0, 6'd1, 6'd0);
    send_op(OP_EQUAL_AT, 32'h0, 6'd1, 6'd0);
    send_op(OP_EQUAL_AT, 32'h0, 6'd2, 6'd0);
    send_op(OP_EXISTS, 32'h8000_0000, 6'd0, 6'd0);
    send_op(OP_SWAP, 32'h0, 6'd0, 6'd2);
    send_op(OP_SWAP, 32'h0, 6'd1, 6'd63);
    send_op(OP_RM_AT, 32'h0, 6'd1, 6'd0);
    send_op(OP_RM_AT, 32'h0, 6'd63, 6'd0);
    send_op(OP_UNUSED_LO, 32'h0, 6'd0, 6'd0);
    send_op(OP_UNUSED_HI, 32'hffff_ffff, 6'd63, 6'd63);
    send_op(OP_CLEAR, 32'h0, 6'd0, 6'd0);

    // random phases with changing mixes and idling patterns
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      prof = phase_plan[phase];
      tx_no_gaps = (phase % 4 == 1);
      rx_no_stalls = (phase % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = pick_op(prof);
        pos = pick_pos(prof);
        pos2 = ($urandom_range(0, 7) == 0) ? pos : pick_pos(prof);
        send_op(op, pick_value(), pos, pos2);
      end
      // hold off until the engine has drained every pending result
      @(negedge clk);
      in_ch.valid = 1'b0;
      while (outstanding != 0) @(posedge clk);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d operations (directed and %0d random phases), %0d results checked",
             items_sent, RANDOM_PHASES, checked_count);
    $display("inserts refused on a full list: %0d", full_hits);
    if (fail_count == 0) begin
      $display("indexed_list_engine verification clean");
    end else begin
      $display("indexed_list_engine verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("indexed_list_engine verification failed");
    $finish;
  end

endmodule
